// ----- design/sector_bitmap_allocator_assert.svh -----
// assertion macros shared by the sector bitmap allocator
`ifndef SECTOR_BITMAP_ALLOCATOR_ASSERT_SVH
`define SECTOR_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SBA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sector bitmap allocator check failed");

// next-cycle implication, checked out of reset
`define SBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sector bitmap allocator check failed");

`endif

// ----- design/sba_pkg.sv -----
// shared constants, codes and control structs of the sector bitmap allocator
`default_nettype none

package sba_pkg;

  localparam int MAX_SECTORS = 65536;
  localparam int WORD_BITS   = 32;
  localparam int WORD_COUNT  = MAX_SECTORS / WORD_BITS;
  localparam int SEC_W       = 16;
  localparam int LEN_W       = 17;
  localparam int CNT_W       = 17;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int TZ_W        = BIT_W + 1;
  localparam int WADDR_W     = $clog2(WORD_COUNT);

  localparam int APB_DW      = 32;
  localparam int PADDR_W     = 3;
  localparam int REG_IDX_W   = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_VOLUME_SECTORS = '0;
  localparam logic [CNT_W-1:0]     VOLUME_RESET       = CNT_W'(65536);

  typedef enum logic [OP_W-1:0] {
    OP_MARK_USED = 2'd0,
    OP_MARK_FREE = 2'd1,
    OP_READ      = 2'd2,
    OP_FIND      = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_NO_RUN = 2'd1,
    ST_RANGE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RES_OK,
    RES_BIT,
    RES_NO_RUN,
    RES_RANGE,
    RES_FOUND
  } res_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_MEMWAIT,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd_item;
    logic wr_item;
    logic scan_rd;
    logic scan_eval;
    logic set_res;
    res_e res;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_range;
    op_e  op;
    logic len_zero;
    logic scan_hit;
    logic scan_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/sba_ctrl.sv -----
// controller state machine: clearing pass, request sequencing and output handshake
`default_nettype none

module sba_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire sba_pkg::sts_t sts_i,
  output sba_pkg::cmd_t      cmd_o
);
  import sba_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res  = RES_OK;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts_i.out_range) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = RES_RANGE;
          state_d       = S_DONE;
        end else if (sts_i.op != OP_FIND) begin
          cmd_o.rd_item = 1'b1;
          state_d       = S_MEMWAIT;
        end else if (sts_i.len_zero) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = RES_NO_RUN;
          state_d       = S_DONE;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_MEMWAIT: begin
        cmd_o.set_res = 1'b1;
        if (sts_i.op == OP_READ) begin
          cmd_o.res = RES_BIT;
        end else begin
          // read-modify-write of the sector's word
          cmd_o.wr_item = 1'b1;
          cmd_o.res     = RES_OK;
        end
        state_d = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_eval = 1'b1;
        priority if (sts_i.scan_hit) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = RES_FOUND;
          state_d       = S_DONE;
        end else if (sts_i.scan_last) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = RES_NO_RUN;
          state_d       = S_DONE;
        end else begin
          // fetch the next word while this one is evaluated
          cmd_o.scan_rd = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- design/sba_dp.sv -----
// datapath: usage bitmap memory, request registers, word-wide run search and result registers
`default_nettype none

module sba_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sba_pkg::cmd_t               cmd_i,
  output sba_pkg::sts_t                    sts_o,
  input  wire logic [sba_pkg::OP_W-1:0]    opcode_i,
  input  wire logic [sba_pkg::SEC_W-1:0]   sector_i,
  input  wire logic [sba_pkg::LEN_W-1:0]   run_length_i,
  input  wire logic [sba_pkg::CNT_W-1:0]   eff_count_i,
  output logic      [sba_pkg::ST_W-1:0]    status_o,
  output logic      [sba_pkg::SEC_W-1:0]   run_start_o,
  output logic                             bit_used_o
);
  import sba_pkg::*;

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rdata_q;

  logic [WADDR_W-1:0]   clr_q;
  op_e                  op_q;
  logic [SEC_W-1:0]     sec_q;
  logic [LEN_W-1:0]     len_q;
  logic [WADDR_W-1:0]   last_w_q;
  logic [BIT_W-1:0]     last_b_q;
  logic [WADDR_W-1:0]   ra_q;
  logic [WADDR_W-1:0]   pw_q;
  logic [LEN_W-1:0]     r_q, r_d;
  logic [SEC_W-1:0]     start_q, start_d;

  logic [ST_W-1:0]      res_status_q;
  logic [SEC_W-1:0]     res_start_q;
  logic                 res_bit_q;
  logic [ST_W-1:0]      out_status_q;
  logic [SEC_W-1:0]     out_start_q;
  logic                 out_bit_q;

  logic [CNT_W-1:0]     cnt_m1;
  logic [WADDR_W-1:0]   item_w;
  logic [BIT_W-1:0]     item_b;
  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mod_word;
  logic                 mem_re;
  logic [WADDR_W-1:0]   mem_raddr;

  logic [WORD_BITS-1:0] lo_mask, hi_mask, free_w;
  logic [TZ_W-1:0]      tz, lf;
  logic [WORD_BITS-1:0] a_v, win_v;
  logic                 len_small;
  logic [BIT_W-1:0]     win_p;
  logic                 win_hit;
  logic                 prefix_hit;
  logic [SEC_W-1:0]     start_hit;
  logic [SEC_W:0]       carry_start;

  assign item_w = sec_q[SEC_W-1:BIT_W];
  assign item_b = sec_q[BIT_W-1:0];
  assign cnt_m1 = eff_count_i - CNT_W'(1);

  // memory port selection
  always_comb begin
    mod_word         = rdata_q;
    mod_word[item_b] = (op_q == OP_MARK_USED);
    mem_we    = cmd_i.clr | cmd_i.wr_item;
    mem_waddr = cmd_i.clr ? clr_q : item_w;
    mem_wdata = cmd_i.clr ? '0 : mod_word;
    mem_re    = cmd_i.rd_item | cmd_i.scan_rd;
    mem_raddr = cmd_i.rd_item ? item_w : ra_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + WADDR_W'(1);
    end
  end

  // word evaluation: bits below the hint and past the volume count as used
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      lo_mask[j] = (pw_q == item_w) && (BIT_W'(j) < item_b);
      hi_mask[j] = (pw_q == last_w_q) && (BIT_W'(j) > last_b_q);
    end
    free_w = ~(rdata_q | lo_mask | hi_mask);
  end

  // free bits from the bottom and from the top of the word
  always_comb begin
    tz = TZ_W'(WORD_BITS);
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!free_w[j]) tz = TZ_W'(j);
    end
    lf = TZ_W'(WORD_BITS);
    for (int j = 0; j < WORD_BITS; j++) begin
      if (!free_w[j]) lf = TZ_W'(WORD_BITS - 1 - j);
    end
  end

  // runs of len_q free bits wholly inside the word, built by doubling
  always_comb begin
    a_v   = free_w;
    win_v = '1;
    for (int k = 0; k <= BIT_W; k++) begin
      if (len_q[k]) begin
        win_v = win_v & (a_v >> (len_q[BIT_W:0] & TZ_W'((1 << k) - 1)));
      end
      a_v = a_v & (a_v >> (1 << k));
    end
  end

  assign len_small = (len_q <= LEN_W'(WORD_BITS));

  always_comb begin
    win_p = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (win_v[j]) win_p = BIT_W'(j);
    end
    win_hit = len_small & (|win_v);
  end

  assign prefix_hit  = ({1'b0, r_q} + (LEN_W + 1)'(tz)) >= {1'b0, len_q};
  assign start_hit   = prefix_hit ? start_q : {pw_q, win_p};
  assign carry_start = {1'b0, pw_q, {BIT_W{1'b0}}} + (SEC_W + 1)'(WORD_BITS)
                       - (SEC_W + 1)'(lf);

  always_comb begin
    if (tz == TZ_W'(WORD_BITS)) begin
      r_d     = r_q + LEN_W'(WORD_BITS);
      start_d = start_q;
    end else begin
      r_d     = LEN_W'(lf);
      start_d = carry_start[SEC_W-1:0];
    end
  end

  // request and scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_e'(opcode_i);
      sec_q    <= sector_i;
      len_q    <= run_length_i;
      ra_q     <= sector_i[SEC_W-1:BIT_W];
      pw_q     <= sector_i[SEC_W-1:BIT_W];
      r_q      <= '0;
      start_q  <= sector_i;
      last_w_q <= cnt_m1[SEC_W-1:BIT_W];
      last_b_q <= cnt_m1[BIT_W-1:0];
    end else begin
      if (cmd_i.scan_rd) ra_q <= ra_q + WADDR_W'(1);
      if (cmd_i.scan_eval) begin
        pw_q    <= pw_q + WADDR_W'(1);
        r_q     <= r_d;
        start_q <= start_d;
      end
    end
  end

  // result and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_res) begin
      unique case (cmd_i.res)
        RES_OK: begin
          res_status_q <= ST_OK;
          res_start_q  <= '0;
          res_bit_q    <= 1'b0;
        end
        RES_BIT: begin
          res_status_q <= ST_OK;
          res_start_q  <= '0;
          res_bit_q    <= rdata_q[item_b];
        end
        RES_NO_RUN: begin
          res_status_q <= ST_NO_RUN;
          res_start_q  <= '0;
          res_bit_q    <= 1'b0;
        end
        RES_RANGE: begin
          res_status_q <= ST_RANGE;
          res_start_q  <= '0;
          res_bit_q    <= 1'b0;
        end
        RES_FOUND: begin
          res_status_q <= ST_OK;
          res_start_q  <= start_hit;
          res_bit_q    <= 1'b0;
        end
        default: begin
          res_status_q <= ST_NO_RUN;
          res_start_q  <= '0;
          res_bit_q    <= 1'b0;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_start_q  <= res_start_q;
      out_bit_q    <= res_bit_q;
    end
  end

  always_comb begin
    sts_o.clr_last  = (clr_q == WADDR_W'(WORD_COUNT - 1));
    sts_o.out_range = ({1'b0, sec_q} >= eff_count_i);
    sts_o.op        = op_q;
    sts_o.len_zero  = (len_q == '0);
    sts_o.scan_hit  = prefix_hit | win_hit;
    sts_o.scan_last = (pw_q == last_w_q);
  end

  assign status_o    = out_status_q;
  assign run_start_o = out_start_q;
  assign bit_used_o  = out_bit_q;

endmodule

`default_nettype wire

// ----- design/sector_bitmap_allocator.sv -----
// mark, free and read pass through S_CHECK, S_MEMWAIT and S_DONE; the result is registered on leaving S_DONE
// out-of-range requests and zero-length finds go from S_CHECK straight to S_DONE; a find stays in S_SCAN
//   for each bitmap word scanned, at most 2048 words, read one word per cycle through the bitmap read port
// after reset a clearing pass zeroes the 2048 bitmap words, one per cycle;
//   no request is taken meanwhile, configuration writes still are
// volume_sectors resets to 65536
`default_nettype none

`include "sector_bitmap_allocator_assert.svh"

module sector_bitmap_allocator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [sba_pkg::OP_W-1:0]      opcode_i,
  input  wire logic [sba_pkg::SEC_W-1:0]     sector_i,
  input  wire logic [sba_pkg::LEN_W-1:0]     run_length_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [sba_pkg::ST_W-1:0]      status_o,
  output logic      [sba_pkg::SEC_W-1:0]     run_start_o,
  output logic                               bit_used_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sba_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [sba_pkg::APB_DW-1:0]    pwdata,
  output logic      [sba_pkg::APB_DW-1:0]    prdata,
  output logic                               pready
);
  import sba_pkg::*;

  logic [CNT_W-1:0]     vol_q;
  logic [CNT_W-1:0]     eff_count;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  cmd_t                 cmd_w;
  sts_t                 sts_w;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q <= VOLUME_RESET;
    end else if (cfg_wr && (reg_idx == REG_VOLUME_SECTORS)) begin
      vol_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_VOLUME_SECTORS) ? APB_DW'(vol_q) : '0;

  // volume size saturates at the bitmap capacity
  assign eff_count = (vol_q > CNT_W'(MAX_SECTORS)) ? CNT_W'(MAX_SECTORS) : vol_q;

  sba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts_w),
    .cmd_o       (cmd_w)
  );

  sba_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_w),
    .sts_o        (sts_w),
    .opcode_i     (opcode_i),
    .sector_i     (sector_i),
    .run_length_i (run_length_i),
    .eff_count_i  (eff_count),
    .status_o     (status_o),
    .run_start_o  (run_start_o),
    .bit_used_o   (bit_used_o)
  );

  `SBA_ASSERT_NEXT(a_one_at_a_time, in_valid_i && !in_stall_o, in_stall_o)
  `SBA_ASSERT_IMPL(a_wr_port_excl, 1'b1, $onehot0({cmd_w.clr, cmd_w.wr_item}))
  `SBA_ASSERT_IMPL(a_rd_port_excl, 1'b1, $onehot0({cmd_w.rd_item, cmd_w.scan_rd}))
  `SBA_ASSERT_IMPL(a_range_clean, out_valid_o && (status_o == ST_RANGE), (run_start_o == '0) && !bit_used_o)
  `SBA_ASSERT_IMPL(a_bit_only_ok, out_valid_o && bit_used_o, (status_o == ST_OK) && (run_start_o == '0))

endmodule

`default_nettype wire

// ----- tb/sv/sector_bitmap_allocator_tb.sv -----
// self-checking testbench of the sector bitmap allocator: marks, reads and first-fit run searches
module sector_bitmap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sba_pkg::*;

  localparam int STUCK_LIMIT = 20000;
  localparam int LONG_HOLD   = 150;
  localparam int SEC_SPAN    = 65535;
  localparam int LEN_SPAN    = 131071;

  typedef struct {
    op_e              op;
    logic [SEC_W-1:0] sector;
    logic [LEN_W-1:0] run_length;
  } alloc_req_t;

  typedef struct {
    status_e          status;
    logic [SEC_W-1:0] run_start;
    logic             bit_used;
  } alloc_res_t;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      opcode     = '0;
  logic [SEC_W-1:0]     sector     = '0;
  logic [LEN_W-1:0]     run_length = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [ST_W-1:0]      status;
  logic [SEC_W-1:0]     run_start;
  logic                 bit_used;
  logic                 psel       = 1'b0;
  logic                 penable    = 1'b0;
  logic                 pwrite     = 1'b0;
  logic [PADDR_W-1:0]   paddr      = '0;
  logic [APB_DW-1:0]    pwdata     = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  // own copy of the bitmap and the volume size
  bit [MAX_SECTORS-1:0] usage_map  = '0;
  logic [CNT_W-1:0]     volume_cfg = VOLUME_RESET;

  alloc_req_t pending_reqs[$];
  alloc_res_t expected_results[$];
  alloc_req_t cur_req;
  logic       idle_on    = 1'b0;
  int         hold_req   = 0;
  int         hold_seen  = 0;
  int         hold_cnt   = 0;
  int         gap_cnt    = 0;
  int         stall_cnt  = 0;
  int         stuck_cyc  = 0;
  int         n_fail     = 0;

  sector_bitmap_allocator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .sector_i     (sector),
    .run_length_i (run_length),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .run_start_o  (run_start),
    .bit_used_o   (bit_used),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic int sector_count();
    return (volume_cfg > MAX_SECTORS) ? MAX_SECTORS : int'(volume_cfg);
  endfunction

  // applies one request to the bitmap copy and returns the result it should give
  function automatic alloc_res_t bitmap_predict(alloc_req_t rq);
    alloc_res_t r;
    int         count;
    int         run;
    int         start;
    int         i;
    bit         found;
    r.status    = ST_OK;
    r.run_start = '0;
    r.bit_used  = 1'b0;
    count       = sector_count();
    if (int'(rq.sector) >= count) begin
      r.status = ST_RANGE;
    end else begin
      case (rq.op)
        OP_MARK_USED: usage_map[rq.sector] = 1'b1;
        OP_MARK_FREE: usage_map[rq.sector] = 1'b0;
        OP_READ:      r.bit_used = usage_map[rq.sector];
        default: begin
          if (rq.run_length == '0) begin
            r.status = ST_NO_RUN;
          end else begin
            run   = 0;
            start = int'(rq.sector);
            found = 1'b0;
            for (i = int'(rq.sector); i < count && !found; i++) begin
              if (!usage_map[i]) begin
                run++;
                if (run == int'(rq.run_length)) found = 1'b1;
              end else begin
                // a used sector restarts the run just past itself
                run   = 0;
                start = i + 1;
              end
            end
            if (found) r.run_start = SEC_W'(start);
            else r.status = ST_NO_RUN;
          end
        end
      endcase
    end
    return r;
  endfunction

  // request side
  always @(posedge clk_i) begin : drive_proc
    alloc_req_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_cnt  <= 0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(bitmap_predict(cur_req));
      if (in_valid && in_stall) begin
        // stalled transaction stays as it is
      end else if (gap_cnt > 0) begin
        gap_cnt  <= gap_cnt - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 && idle_on && $urandom_range(0, 4) == 0) begin
        gap_cnt  <= $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt        = pending_reqs.pop_front();
        cur_req    <= nxt;
        opcode     <= nxt.op;
        sector     <= nxt.sector;
        run_length <= nxt.run_length;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: check and stall
  always @(posedge clk_i) begin : check_proc
    alloc_res_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            n_fail++;
          end
          if (run_start !== want.run_start) begin
            $error("run_start: expected %0d, got %0d", want.run_start, run_start);
            n_fail++;
          end
          if (bit_used !== want.bit_used) begin
            $error("bit_used: expected %0d, got %0d", want.bit_used, bit_used);
            n_fail++;
          end
        end
      end
      // a long hold-off lets the block back up into its input
      if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_cnt  <= LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_cnt <= $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog_proc
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cyc <= 0;
    end else if (stuck_cyc >= STUCK_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cyc <= stuck_cyc + 1;
    end
  end

  task automatic queue_req(input op_e op, input int sec, input int len);
    alloc_req_t rq;
    rq.op         = op;
    rq.sector     = SEC_W'(sec);
    rq.run_length = LEN_W'(len);
    pending_reqs.push_back(rq);
  endtask

  task automatic queue_random(input int n);
    alloc_req_t rq;
    int         count;
    int         pick;
    count = sector_count();
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) rq.op = OP_MARK_USED;
      else if (pick < 50) rq.op = OP_MARK_FREE;
      else if (pick < 70) rq.op = OP_READ;
      else rq.op = OP_FIND;
      pick = $urandom_range(0, 99);
      if (count == 0 || pick < 8) begin
        rq.sector = SEC_W'($urandom_range(0, SEC_SPAN));
      end else if (pick < 18 && count < MAX_SECTORS) begin
        rq.sector = SEC_W'($urandom_range(count, SEC_SPAN));
      end else if (pick < 45) begin
        // near the top of the volume, where long runs fall off the end
        rq.sector = SEC_W'($urandom_range(count > 64 ? count - 64 : 0, count - 1));
      end else begin
        rq.sector = SEC_W'($urandom_range(0, count - 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) rq.run_length = '0;
      else if (pick < 15) rq.run_length = LEN_W'($urandom_range(0, LEN_SPAN));
      else if (pick < 27 && count > 0) rq.run_length = LEN_W'($urandom_range(1, count));
      else rq.run_length = LEN_W'($urandom_range(1, 12));
      pending_reqs.push_back(rq);
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // waits for the block to go idle, then sets a new volume size
  task automatic begin_phase(input int vol, input logic idle);
    drain();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_VOLUME_SECTORS, 2'b00});
    pwdata  <= APB_DW'(vol);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    volume_cfg =  CNT_W'(vol);
    idle_on    <= idle;
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni  <= 1'b1;
    idle_on <= 1'b1;

    // full volume, bitmap fresh from the clearing pass
    queue_req(OP_FIND, 0, 65536);
    queue_req(OP_FIND, 0, LEN_SPAN);
    queue_req(OP_FIND, 5, 0);
    queue_req(OP_MARK_USED, 0, 0);
    queue_req(OP_MARK_USED, 31, 0);
    queue_req(OP_MARK_USED, 32, 0);
    queue_req(OP_MARK_USED, SEC_SPAN, LEN_SPAN);
    queue_req(OP_READ, 0, 0);
    queue_req(OP_READ, SEC_SPAN, 0);
    queue_req(OP_READ, 1, 0);
    queue_req(OP_FIND, 0, 1);
    queue_req(OP_FIND, 0, 31);
    queue_req(OP_FIND, SEC_SPAN, 1);
    queue_req(OP_FIND, SEC_SPAN - 1, 2);
    queue_req(OP_FIND, SEC_SPAN - 1, 1);
    queue_req(OP_MARK_FREE, 0, 0);
    queue_req(OP_READ, 0, 0);
    queue_req(OP_MARK_FREE, 100, 0);

    // volume of eight sectors: out-of-range sectors and hints
    begin_phase(8, 1'b1);
    queue_req(OP_MARK_USED, 8, 0);
    queue_req(OP_READ, SEC_SPAN, 0);
    queue_req(OP_FIND, 8, 1);
    queue_req(OP_MARK_USED, 7, 0);
    queue_req(OP_FIND, 0, 8);
    queue_req(OP_FIND, 0, 7);
    queue_req(OP_FIND, 7, 1);

    // oversized setting saturates to the full volume
    begin_phase(LEN_SPAN, 1'b0);
    queue_req(OP_FIND, SEC_SPAN, 1);
    queue_req(OP_READ, SEC_SPAN, 0);
    queue_req(OP_MARK_FREE, SEC_SPAN, 0);

    begin_phase(100, 1'b1);
    queue_random(45);

    begin_phase(1000, 1'b1);
    hold_req <= hold_req + 1;
    queue_random(45);

    begin_phase(0, 1'b1);
    queue_random(6);

    begin_phase(5, 1'b0);
    queue_random(15);

    begin_phase(LEN_SPAN, 1'b1);
    queue_random(35);

    begin_phase(40, 1'b1);
    queue_random(45);

    begin_phase(65536, 1'b1);
    queue_random(40);

    // closing stretch runs without any idling
    begin_phase(300, 1'b0);
    queue_random(35);

    drain();
    repeat (50) @(posedge clk_i);
    if (n_fail == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
